// ===== design/ufpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufpc_pkg
// Shared types and operation codes for the union-find engine.
// ----------------------------------------------------------------------------
package ufpc_pkg;

  localparam int IDX_W = 10;
  localparam int OP_W  = 2;

  localparam logic [OP_W-1:0] OP_FIND  = 2'd0;
  localparam logic [OP_W-1:0] OP_UNITE = 2'd1;
  localparam logic [OP_W-1:0] OP_SAME  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
  } req_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] root_a;
    logic             same_set;
  } rsp_item_t;

endpackage

// ===== design/ufpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufpc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ufpc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/union_find_path_compression_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_path_compression_top
// Disjoint-set engine: find, unite and same-set query over a parent table
// held in one RAM, with full path compression on every find.
//
// Request channel (req_valid / req_stall / req): one item per operation.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one item per request,
// in order, carrying the root of index_a and the same-set flag.
// One item is worked on at a time; req_stall is low only while idle.
// Each find of an in-range index runs a launch step, a walk of one RAM read
// per link from the index to its root plus the root check, and a compression
// re-walk that writes each node while reading its parent. An out-of-range
// index skips the walk and the compression. Find items take one find, other
// items two, plus a step to accept the item and one to load the response.
// The parent RAM read port sets the pace of the walk: one link per cycle.
// After reset the block runs a clearing pass that writes every entry with its
// own index; req_stall stays high until it is done.
// A stalled response holds in its output register; the block may still accept
// and work the next item, but then waits in ST_FINISH, loading no new
// response until the held one leaves.
// ----------------------------------------------------------------------------
module union_find_path_compression_top
  import ufpc_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SIZE - 1);

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_LAUNCH   = 6'b000100,
    ST_WALK     = 6'b001000,
    ST_COMPRESS = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_t;

  state_t state, state_next;

  req_item_t        item;
  logic             second;
  logic [AW-1:0]    clr_cnt;
  logic [AW-1:0]    cur;
  logic [AW-1:0]    root;
  logic [IDX_W-1:0] ra;
  logic [IDX_W-1:0] rb;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [AW-1:0]    ram_rdata;

  logic [IDX_W-1:0] start;
  logic [AW-1:0]    start_addr;
  logic             start_in;
  logic             last_find;
  logic             load;
  logic             same;
  logic             unite_write;

  ufpc_ram #(
    .WIDTH(AW),
    .DEPTH(TABLE_SIZE)
  ) u_parent (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign start       = second ? item.index_b : item.index_a;
  assign start_addr  = AW'(start);
  assign start_in    = 32'(start) < TABLE_SIZE;
  assign last_find   = second || (item.operation == OP_FIND);
  assign load        = (state == ST_FINISH) && (!rsp_valid || !rsp_stall);
  assign same        = (item.operation != OP_FIND) && (ra == rb);
  assign unite_write = (item.operation == OP_UNITE) && (ra != rb) &&
                       (32'(ra) < TABLE_SIZE) && (32'(rb) < TABLE_SIZE);
  assign req_stall   = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cur;
    ram_wdata  = root;
    ram_raddr  = start_addr;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = clr_cnt;
        if (clr_cnt == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (!start_in) begin
          state_next = last_find ? ST_FINISH : ST_LAUNCH;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (ram_rdata == cur) begin
          state_next = ST_COMPRESS;
        end else begin
          ram_raddr = ram_rdata;
        end
      end
      ST_COMPRESS: begin
        ram_raddr = ram_rdata;
        if (ram_rdata == root) begin
          state_next = last_find ? ST_FINISH : ST_LAUNCH;
        end else begin
          ram_we = 1'b1;
        end
      end
      ST_FINISH: begin
        ram_waddr = AW'(rb);
        ram_wdata = AW'(ra);
        if (load) begin
          ram_we     = unite_write;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      second    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ST_IDLE && req_valid) begin
        second <= 1'b0;
      end
      if (state == ST_LAUNCH && !start_in) begin
        second <= 1'b1;
      end
      if (state == ST_COMPRESS && ram_rdata == root) begin
        second <= 1'b1;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      item <= req;
    end
    if (state == ST_LAUNCH) begin
      cur <= start_addr;
      if (!start_in) begin
        if (second) begin
          rb <= start;
        end else begin
          ra <= start;
        end
      end
    end
    if (state == ST_WALK) begin
      if (ram_rdata == cur) begin
        root <= cur;
        cur  <= start_addr;
      end else begin
        cur <= ram_rdata;
      end
    end
    if (state == ST_COMPRESS) begin
      if (ram_rdata == root) begin
        if (second) begin
          rb <= IDX_W'(root);
        end else begin
          ra <= IDX_W'(root);
        end
      end else begin
        cur <= ram_rdata;
      end
    end
    if (load) begin
      rsp.root_a   <= ra;
      rsp.same_set <= same;
    end
  end

  a_no_rsp_during_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !rsp_valid)
    else $error("response during clearing pass");

  a_accept_launches: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == ST_LAUNCH))
    else $error("accepted item did not launch");

  a_compress_not_root: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == ST_COMPRESS) |-> (ram_waddr != root))
    else $error("compression rewrote the root");

  a_unite_no_self_link: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == ST_FINISH) |-> (ram_wdata != ram_waddr))
    else $error("unite wrote a self link");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_FINISH))
    else $error("response raised outside finish");

endmodule
